@@ src/tbs_pkg.sv @@
package tbs_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 4096;
	localparam int MaxBoxes  = 64;
	localparam int NumBanks  = 2;

	localparam int ColW    = $clog2(MaxWidth);
	localparam int RowW    = $clog2(MaxHeight);
	localparam int WidthW  = $clog2(MaxWidth + 1);
	localparam int HeightW = $clog2(MaxHeight + 1);
	localparam int CntW    = $clog2(MaxBoxes + 1);
	localparam int BoxIdxW = $clog2(MaxBoxes);
	localparam int ChanW   = 8;

	localparam logic [ChanW-1:0]   ChanFull    = 8'hFF;
	localparam logic [ColW-1:0]    LastCol     = ColW'(MaxWidth - 1);
	localparam logic [WidthW-1:0]  WidthLimit  = WidthW'(MaxWidth);
	localparam logic [HeightW-1:0] HeightLimit = HeightW'(MaxHeight);
	localparam logic [WidthW-1:0]  ResetWidth  = 11'd1024;
	localparam logic [HeightW-1:0] ResetHeight = 13'd1024;

	// register indexes on the configuration port
	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	// band close request handed from front to back
	typedef struct packed {
		logic              bank;
		logic [RowW-1:0]   top;
		logic [RowW-1:0]   bottom;
		logic [WidthW-1:0] width;
	} cmd_t;

	// ink write into the column store
	typedef struct packed {
		logic            en;
		logic            bank;
		logic [ColW-1:0] addr;
	} ink_wr_t;

endpackage

@@ src/text_box_segmenter.sv @@
// Pixels: one word per cycle while the column store bank in use is free.
// Band close: the back walks the closed bank (one column a cycle, read port of the
// bank), then reads out its boxes one per cycle while box_stall is low.
// After a second close, pixels stall until the walk ends.
// Reset: width and height go to 1024; a clearing pass then zeroes
// both column store banks while pix_stall stays high (configuration is taken as usual).
module text_box_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        box_valid,
	input  logic        box_stall,
	output logic [9:0]  box_left,
	output logic [9:0]  box_right,
	output logic [11:0] band_top,
	output logic [11:0] band_bottom,
	output logic        last_box,
	output logic        box_overflow
);
	import tbs_pkg::*;

	logic [WidthW-1:0]   width_q;
	logic [HeightW-1:0]  height_q;
	logic                cfg_wr;

	logic [NumBanks-1:0] release_mask;
	logic                q_full;
	logic                q_empty;
	logic                q_push;
	logic                q_pop;
	cmd_t                push_cmd;
	cmd_t                head_cmd;
	ink_wr_t             ink_wr;

	// Register file: word index taken from paddr[2], byte offset ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
		end else if (cfg_wr) begin
			case (paddr[2])
				RegWidth:  width_q  <= pwdata[WidthW-1:0];
				RegHeight: height_q <= pwdata[HeightW-1:0];
				default:   width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			RegWidth:  prdata = {{(32 - WidthW){1'b0}}, width_q};
			RegHeight: prdata = {{(32 - HeightW){1'b0}}, height_q};
			default:   prdata = '0;
		endcase
	end

	// Front: classify each word as ink, mark its column, track rows and bands,
	// and hand a close request over when a band ends.
	tbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.width_reg    (width_q),
		.height_reg   (height_q),
		.release_mask (release_mask),
		.q_full       (q_full),
		.push         (q_push),
		.push_cmd     (push_cmd),
		.wr           (ink_wr)
	);

	// Close requests wait here until the back is free.
	tbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	// Back: hold both column store banks, walk and clear a closed bank,
	// buffer its boxes and drive them out through the output register.
	tbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (ink_wr),
		.q_empty      (q_empty),
		.head_cmd     (head_cmd),
		.q_pop        (q_pop),
		.release_mask (release_mask),
		.box_valid    (box_valid),
		.box_stall    (box_stall),
		.box_left     (box_left),
		.box_right    (box_right),
		.band_top     (band_top),
		.band_bottom  (band_bottom),
		.last_box     (last_box),
		.box_overflow (box_overflow)
	);

endmodule

@@ src/tbs_queue.sv @@
module tbs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tbs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output tbs_pkg::cmd_t head_cmd,
	output logic          empty
);
	import tbs_pkg::*;

	cmd_t       slot_q [NumBanks];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign head_cmd = slot_q[rp_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/tbs_front.sv @@
module tbs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [tbs_pkg::WidthW-1:0]      width_reg,
	input  logic [tbs_pkg::HeightW-1:0]     height_reg,
	input  logic [tbs_pkg::NumBanks-1:0]    release_mask,
	input  logic                            q_full,
	output logic                            push,
	output tbs_pkg::cmd_t                   push_cmd,
	output tbs_pkg::ink_wr_t                wr
);
	import tbs_pkg::*;

	logic [ColW-1:0]     col_q;
	logic [RowW-1:0]     row_q;
	logic                in_band_q;
	logic [RowW-1:0]     start_row_q;
	logic                row_ink_q;
	logic                cur_q;
	logic [NumBanks-1:0] busy_q;

	logic [WidthW-1:0]   eff_w;
	logic [HeightW-1:0]  eff_h;
	logic                accept;
	logic                ink;
	logic                row_ink;
	logic                end_row;
	logic                last_row;
	logic                close;
	logic [NumBanks-1:0] set_mask;

	always_comb begin
		eff_w = width_reg;
		if (width_reg == '0) begin
			eff_w = WidthW'(1);
		end else if (width_reg > WidthLimit) begin
			eff_w = WidthLimit;
		end
		eff_h = height_reg;
		if (height_reg == '0) begin
			eff_h = HeightW'(1);
		end else if (height_reg > HeightLimit) begin
			eff_h = HeightLimit;
		end
	end

	// hold pixels while the bank in use is busy (queued, walked, or cleared after reset) or the queue is full
	assign pix_stall = busy_q[cur_q] | q_full;
	assign accept    = pix_valid & ~pix_stall;

	assign ink      = !(red == ChanFull && green == ChanFull && blue == ChanFull);
	assign row_ink  = row_ink_q | ink;
	assign end_row  = ({1'b0, col_q} + WidthW'(1)) >= eff_w;
	assign last_row = ({1'b0, row_q} + HeightW'(1)) >= eff_h;
	assign close    = accept && end_row &&
		((row_ink && last_row) || (!row_ink && in_band_q));

	assign wr.en   = accept & ink;
	assign wr.bank = cur_q;
	assign wr.addr = col_q;

	assign push            = close;
	assign push_cmd.bank   = cur_q;
	assign push_cmd.top    = in_band_q ? start_row_q : row_q;
	assign push_cmd.bottom = row_ink ? row_q : row_q - RowW'(1);
	assign push_cmd.width  = eff_w;

	always_comb begin
		set_mask = '0;
		if (close) begin
			set_mask[cur_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			in_band_q   <= 1'b0;
			start_row_q <= '0;
			row_ink_q   <= 1'b0;
			cur_q       <= 1'b0;
			busy_q      <= '1;
		end else begin
			busy_q <= (busy_q & ~release_mask) | set_mask;
			if (accept) begin
				if (!end_row) begin
					col_q     <= col_q + ColW'(1);
					row_ink_q <= row_ink;
				end else begin
					col_q     <= '0;
					row_ink_q <= 1'b0;
					if (row_ink && !in_band_q) begin
						start_row_q <= row_q;
					end
					if (last_row) begin
						row_q     <= '0;
						in_band_q <= 1'b0;
					end else begin
						row_q     <= row_q + RowW'(1);
						in_band_q <= row_ink;
					end
					if (close) begin
						cur_q <= ~cur_q;
					end
				end
			end
		end
	end

endmodule

@@ src/tbs_back.sv @@
module tbs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbs_pkg::ink_wr_t             wr,
	input  logic                         q_empty,
	input  tbs_pkg::cmd_t                head_cmd,
	output logic                         q_pop,
	output logic [tbs_pkg::NumBanks-1:0] release_mask,
	output logic                         box_valid,
	input  logic                         box_stall,
	output logic [9:0]                   box_left,
	output logic [9:0]                   box_right,
	output logic [11:0]                  band_top,
	output logic [11:0]                  band_bottom,
	output logic                         last_box,
	output logic                         box_overflow
);
	import tbs_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t state_q;

	logic mem0 [MaxWidth];
	logic mem1 [MaxWidth];
	logic [2*ColW-1:0] box_mem [MaxBoxes];

	logic              rd0_q;
	logic              rd1_q;
	logic [ColW-1:0]   x_q;
	logic              issue_q;
	logic              bank_q;
	logic [RowW-1:0]   top_q;
	logic [RowW-1:0]   bottom_q;
	logic [WidthW-1:0] w_q;

	logic              v_s1;
	logic              last_s1;
	logic [ColW-1:0]   x_s1;

	logic              open_q;
	logic [ColW-1:0]   start_q;
	logic [CntW-1:0]   cnt_q;
	logic              ovf_q;

	logic [CntW-1:0]   rp_q;
	logic              rv_s1;
	logic [BoxIdxW-1:0] idx_s1;
	logic [2*ColW-1:0] box_s1;
	logic              out_valid_q;

	logic              we0;
	logic              we1;
	logic [ColW-1:0]   wa0;
	logic [ColW-1:0]   wa1;
	logic              wd0;
	logic              wd1;
	logic              sweep;

	logic              eff;
	logic              em;
	logic [ColW-1:0]   em_left;
	logic [ColW-1:0]   em_right;
	logic              open_d;
	logic [ColW-1:0]   start_d;
	logic              room;
	logic [CntW-1:0]   cnt_d;
	logic              walk_done;

	logic              rd_issue;
	logic              load;

	// column store write ports: pixel ink from the front, zeroes from the sweep
	assign sweep = (state_q == ST_CLEAR) || (state_q == ST_WALK && issue_q);

	always_comb begin
		we0 = 1'b0;
		wa0 = x_q;
		wd0 = 1'b0;
		we1 = 1'b0;
		wa1 = x_q;
		wd1 = 1'b0;
		if (wr.en && !wr.bank) begin
			we0 = 1'b1;
			wa0 = wr.addr;
			wd0 = 1'b1;
		end else if (sweep && (state_q == ST_CLEAR || !bank_q)) begin
			we0 = 1'b1;
		end
		if (wr.en && wr.bank) begin
			we1 = 1'b1;
			wa1 = wr.addr;
			wd1 = 1'b1;
		end else if (sweep && (state_q == ST_CLEAR || bank_q)) begin
			we1 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa0] <= wd0;
		end
		rd0_q <= mem0[x_q];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[wa1] <= wd1;
		end
		rd1_q <= mem1[x_q];
	end

	// run detection on the column just read
	assign eff  = v_s1 && (bank_q ? rd1_q : rd0_q) && ({1'b0, x_s1} < w_q);
	assign room = cnt_q < CntW'(MaxBoxes);

	always_comb begin
		em       = 1'b0;
		em_left  = start_q;
		em_right = x_s1 - ColW'(1);
		open_d   = open_q;
		start_d  = start_q;
		if (v_s1) begin
			if (eff && !open_q) begin
				open_d  = 1'b1;
				start_d = x_s1;
				if (last_s1) begin
					em       = 1'b1;
					em_left  = x_s1;
					em_right = x_s1;
				end
			end else if (eff && open_q) begin
				if (last_s1) begin
					em       = 1'b1;
					em_right = x_s1;
				end
			end else if (open_q) begin
				em     = 1'b1;
				open_d = 1'b0;
			end
		end
	end

	assign cnt_d     = (em && room) ? cnt_q + CntW'(1) : cnt_q;
	assign walk_done = (state_q == ST_WALK) && v_s1 && last_s1;

	always_comb begin
		release_mask = '0;
		if (state_q == ST_CLEAR && x_q == LastCol) begin
			release_mask = '1;
		end else if (walk_done) begin
			release_mask[bank_q] = 1'b1;
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// box buffer: filled during the walk, read out once the overflow state is known
	assign load     = rv_s1 && (!out_valid_q || !box_stall);
	assign rd_issue = (state_q == ST_DRAIN) && (rp_q != cnt_q) && (!rv_s1 || load);

	always_ff @(posedge clk) begin
		if (em && room) begin
			box_mem[cnt_q[BoxIdxW-1:0]] <= {em_left, em_right};
		end
		if (rd_issue) begin
			box_s1 <= box_mem[rp_q[BoxIdxW-1:0]];
			idx_s1 <= rp_q[BoxIdxW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bank_q   <= head_cmd.bank;
			top_q    <= head_cmd.top;
			bottom_q <= head_cmd.bottom;
			w_q      <= head_cmd.width;
		end
		x_s1    <= x_q;
		last_s1 <= (x_q == LastCol);
		start_q <= start_d;
		if (load) begin
			box_left     <= box_s1[2*ColW-1:ColW];
			box_right    <= box_s1[ColW-1:0];
			band_top     <= top_q;
			band_bottom  <= bottom_q;
			last_box     <= ({1'b0, idx_s1} == cnt_q - CntW'(1));
			box_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			x_q         <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			open_q      <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			rp_q        <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= (state_q == ST_WALK) && issue_q;
			rv_s1       <= rd_issue | (rv_s1 & ~load);
			out_valid_q <= load | (out_valid_q & box_stall);
			if (rd_issue) begin
				rp_q <= rp_q + CntW'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					x_q <= x_q + ColW'(1);
					if (x_q == LastCol) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_WALK;
						x_q     <= '0;
						issue_q <= 1'b1;
						open_q  <= 1'b0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
					end
				end
				ST_WALK: begin
					if (issue_q) begin
						x_q <= x_q + ColW'(1);
						if (x_q == LastCol) begin
							issue_q <= 1'b0;
						end
					end
					open_q <= open_d;
					cnt_q  <= cnt_d;
					if (em && !room) begin
						ovf_q <= 1'b1;
					end
					if (walk_done) begin
						rp_q    <= '0;
						state_q <= (cnt_d == '0) ? ST_IDLE : ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (rp_q == cnt_q && !rv_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign box_valid = out_valid_q;

endmodule
